@@ design/swsp_pkg.sv @@
// ============================================================================
// swsp_pkg: shared types and constants of the single-wire sensor link
// Frame constants, pulse qualification limits, command and result codes,
// and the per-item snapshot passed from the controller to the output queue.
// ============================================================================
package swsp_pkg;

    // Frame bytes that do not depend on the request.
    localparam logic [7:0] FRAME_HEAD = 8'h1E;
    localparam logic [7:0] FRAME_ADDR = 8'h05;
    localparam logic [7:0] FRAME_TAIL = 8'h1F;

    // Line turnaround and pulse qualification, in ticks.
    localparam logic [4:0] TURN_TICKS = 5'd15;
    localparam logic [4:0] TURN_MAX   = 5'd31;
    localparam logic [7:0] PULSE_MIN  = 8'd3;
    localparam logic [7:0] PULSE_MAX  = 8'd7;
    localparam logic [8:0] TOLERANCE  = 9'd4;
    localparam logic [7:0] COUNT_MAX  = 8'hFF;

    // Input command codes.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Result kind codes.
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FRAME  = 1'b1;

    // Outcome codes.
    localparam logic [1:0] OUTCOME_NONE = 2'd0;
    localparam logic [1:0] OUTCOME_PASS = 2'd1;
    localparam logic [1:0] OUTCOME_FAIL = 2'd2;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_CHECK_CODE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CALIB_CODE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHECK_PULSES  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CALIB_PULSES  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CHECK_RETRIES = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CALIB_RETRIES = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CHECK_WAIT    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_CALIB_WAIT    = 3'd7;

    // Beat positions in the output queue: five frame bytes, then status.
    localparam logic [2:0] IDX_HEAD   = 3'd0;
    localparam logic [2:0] IDX_ADDR   = 3'd1;
    localparam logic [2:0] IDX_CODE   = 3'd2;
    localparam logic [2:0] IDX_SUM    = 3'd3;
    localparam logic [2:0] IDX_TAIL   = 3'd4;
    localparam logic [2:0] IDX_STATUS = 3'd5;

    // State of the link after one item, shared by all beats of that item.
    typedef struct packed {
        logic       has_frame;
        logic [7:0] code;
        logic       line_drive;
        logic       busy;
        logic [1:0] outcome;
        logic [7:0] pulse_count;
        logic [7:0] retries;
    } swsp_snap_t;

endpackage

@@ design/swsp_ctrl.sv @@
// ============================================================================
// swsp_ctrl: request controller of the single-wire sensor link
// Holds the configuration registers and the link state, and applies one
// input item per step in a single pass of logic.
// ============================================================================
module swsp_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [swsp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [swsp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                step,
    input  logic                                cmd,
    input  logic                                request_kind,
    input  logic                                pin_level,
    output swsp_pkg::swsp_snap_t                snap
);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_SEND   = 2'd1;
    localparam logic [1:0] PH_DRIVE  = 2'd2;
    localparam logic [1:0] PH_LISTEN = 2'd3;

    localparam logic [1:0] PP_CLEAR = 2'd0;
    localparam logic [1:0] PP_LOW   = 2'd1;
    localparam logic [1:0] PP_HIGH  = 2'd2;

    logic [7:0]  check_code_reg, calib_code_reg;
    logic [7:0]  check_pulses_reg, calib_pulses_reg;
    logic [7:0]  check_retries_reg, calib_retries_reg;
    logic [15:0] check_wait_reg, calib_wait_reg;

    logic [1:0]  phase_reg, phase_next;
    logic        is_calib_reg, is_calib_next;
    logic [7:0]  retries_reg, retries_next;
    logic [1:0]  pp_reg, pp_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  ptimer_reg, ptimer_next;
    logic [4:0]  turn_reg, turn_next;
    logic [15:0] wait_reg, wait_next;
    logic        prior_reg, prior_next;

    logic [7:0]  code_sel;
    logic [7:0]  expected;
    logic [4:0]  turn_inc;
    logic [15:0] wait_dec;
    logic [7:0]  ptimer_inc;
    logic        in_window;
    logic        has_frame;
    logic [1:0]  outcome;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_code_reg    <= 8'd1;
            calib_code_reg    <= 8'd2;
            check_pulses_reg  <= 8'd10;
            calib_pulses_reg  <= 8'd20;
            check_retries_reg <= 8'd3;
            calib_retries_reg <= 8'd3;
            check_wait_reg    <= 16'd250;
            calib_wait_reg    <= 16'd500;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                swsp_pkg::REG_CHECK_CODE:    check_code_reg    <= cfg_data[7:0];
                swsp_pkg::REG_CALIB_CODE:    calib_code_reg    <= cfg_data[7:0];
                swsp_pkg::REG_CHECK_PULSES:  check_pulses_reg  <= cfg_data[7:0];
                swsp_pkg::REG_CALIB_PULSES:  calib_pulses_reg  <= cfg_data[7:0];
                swsp_pkg::REG_CHECK_RETRIES: check_retries_reg <= cfg_data[7:0];
                swsp_pkg::REG_CALIB_RETRIES: calib_retries_reg <= cfg_data[7:0];
                swsp_pkg::REG_CHECK_WAIT:    check_wait_reg    <= cfg_data;
                swsp_pkg::REG_CALIB_WAIT:    calib_wait_reg    <= cfg_data;
                default:                     check_code_reg    <= check_code_reg;
            endcase
        end
    end

    assign code_sel   = is_calib_reg ? calib_code_reg : check_code_reg;
    assign expected   = is_calib_reg ? calib_pulses_reg : check_pulses_reg;
    assign turn_inc   = (turn_reg != swsp_pkg::TURN_MAX) ? turn_reg + 5'd1 : turn_reg;
    assign wait_dec   = (wait_reg != 16'd0) ? wait_reg - 16'd1 : wait_reg;
    assign ptimer_inc = (ptimer_reg != 8'hFF) ? ptimer_reg + 8'd1 : ptimer_reg;

    // The window is taken in nine bits so that it does not wrap near 0 or 255.
    assign in_window = (({1'b0, count_next} + swsp_pkg::TOLERANCE) >= {1'b0, expected})
                    && ({1'b0, count_next} <= ({1'b0, expected} + swsp_pkg::TOLERANCE));

    always_comb
    begin
        phase_next    = phase_reg;
        is_calib_next = is_calib_reg;
        retries_next  = retries_reg;
        pp_next       = pp_reg;
        count_next    = count_reg;
        ptimer_next   = ptimer_reg;
        turn_next     = turn_reg;
        wait_next     = wait_reg;
        prior_next    = prior_reg;
        has_frame     = 1'b0;
        outcome       = swsp_pkg::OUTCOME_NONE;

        if (cmd == swsp_pkg::CMD_START)
        begin
            is_calib_next = request_kind;
            retries_next  = request_kind ? calib_retries_reg : check_retries_reg;
            phase_next    = PH_SEND;
            wait_next     = 16'd0;
        end
        else
        begin
            prior_next = pin_level;
            case (phase_reg)
                PH_SEND:
                begin
                    has_frame   = 1'b1;
                    phase_next  = PH_DRIVE;
                    pp_next     = PP_CLEAR;
                    count_next  = 8'd0;
                    ptimer_next = 8'd0;
                    turn_next   = 5'd0;
                    wait_next   = is_calib_reg ? calib_wait_reg : check_wait_reg;
                end
                PH_DRIVE:
                begin
                    turn_next = turn_inc;
                    wait_next = wait_dec;
                    if (turn_inc > swsp_pkg::TURN_TICKS)
                    begin
                        phase_next = PH_LISTEN;
                    end
                end
                PH_LISTEN:
                begin
                    wait_next   = wait_dec;
                    ptimer_next = ptimer_inc;
                    if (!pin_level && prior_reg)
                    begin
                        if (pp_reg == PP_CLEAR)
                        begin
                            ptimer_next = 8'd0;
                            pp_next     = PP_LOW;
                        end
                        else if (pp_reg == PP_HIGH && ptimer_inc < swsp_pkg::PULSE_MIN)
                        begin
                            pp_next = PP_CLEAR;
                        end
                    end
                    else if (pin_level && !prior_reg)
                    begin
                        if (pp_reg == PP_LOW)
                        begin
                            if (ptimer_inc >= swsp_pkg::PULSE_MIN
                                && ptimer_inc <= swsp_pkg::PULSE_MAX)
                            begin
                                ptimer_next = 8'd0;
                                pp_next     = PP_HIGH;
                            end
                            else
                            begin
                                pp_next = PP_CLEAR;
                            end
                        end
                    end
                    else if (pin_level && prior_reg)
                    begin
                        if (pp_reg == PP_HIGH && ptimer_inc >= swsp_pkg::PULSE_MIN)
                        begin
                            if (count_reg != swsp_pkg::COUNT_MAX)
                            begin
                                count_next = count_reg + 8'd1;
                            end
                            pp_next = PP_CLEAR;
                        end
                    end

                    if (wait_dec == 16'd0)
                    begin
                        if (in_window)
                        begin
                            phase_next = PH_IDLE;
                            outcome    = swsp_pkg::OUTCOME_PASS;
                        end
                        else if (retries_reg <= 8'd1)
                        begin
                            retries_next = 8'd0;
                            phase_next   = PH_IDLE;
                            outcome      = swsp_pkg::OUTCOME_FAIL;
                        end
                        else
                        begin
                            retries_next = retries_reg - 8'd1;
                            phase_next   = PH_SEND;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            is_calib_reg <= 1'b0;
            retries_reg  <= 8'd0;
            pp_reg       <= PP_CLEAR;
            count_reg    <= 8'd0;
            ptimer_reg   <= 8'd0;
            turn_reg     <= 5'd0;
            wait_reg     <= 16'd0;
            prior_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            is_calib_reg <= is_calib_next;
            retries_reg  <= retries_next;
            pp_reg       <= pp_next;
            count_reg    <= count_next;
            ptimer_reg   <= ptimer_next;
            turn_reg     <= turn_next;
            wait_reg     <= wait_next;
            prior_reg    <= prior_next;
        end
    end

    // Every beat of an item reports the state as it stands after the item.
    assign snap.has_frame   = has_frame;
    assign snap.code        = code_sel;
    assign snap.line_drive  = (phase_next == PH_DRIVE);
    assign snap.busy        = (phase_next != PH_IDLE);
    assign snap.outcome     = outcome;
    assign snap.pulse_count = count_next;
    assign snap.retries     = retries_next;

    a_send_makes_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (step && cmd == swsp_pkg::CMD_TICK && phase_reg == PH_SEND) |-> snap.has_frame)
        else $error("send tick did not produce a frame");

    a_outcome_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
        (step && snap.outcome != swsp_pkg::OUTCOME_NONE) |=> (phase_reg == PH_IDLE))
        else $error("request did not end after an outcome");

    a_listen_after_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LISTEN) |-> (turn_reg > swsp_pkg::TURN_TICKS))
        else $error("listening before the turnaround time");

    a_start_clears_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (step && cmd == swsp_pkg::CMD_START) |=> (phase_reg == PH_SEND && wait_reg == 16'd0))
        else $error("start did not load a send");

endmodule

@@ design/swsp_txq.sv @@
// ============================================================================
// swsp_txq: result queue of the single-wire sensor link
// Holds the results of one item and hands them out one beat per cycle
// unless stalled: five frame bytes when the item sent a frame, then status.
// ============================================================================
module swsp_txq (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  swsp_pkg::swsp_snap_t    snap,
    output logic                    free,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    kind,
    output logic [7:0]              frame_byte,
    output logic                    last,
    output logic                    line_drive,
    output logic                    busy_res,
    output logic [1:0]              outcome,
    output logic [7:0]              pulses_seen,
    output logic [7:0]              retries_remaining
);

    logic                   valid_reg;
    logic [2:0]             idx_reg;
    swsp_pkg::swsp_snap_t   snap_reg;
    logic                   on_status;
    logic [7:0]             sum;

    assign on_status = (idx_reg == swsp_pkg::IDX_STATUS);
    // The queue frees up in the same cycle that its status beat leaves.
    assign free      = !valid_reg || (on_status && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= swsp_pkg::IDX_STATUS;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= snap.has_frame ? swsp_pkg::IDX_HEAD : swsp_pkg::IDX_STATUS;
        end
        else if (valid_reg && out_ready)
        begin
            if (on_status)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            snap_reg <= snap;
        end
    end

    assign sum = swsp_pkg::FRAME_HEAD + swsp_pkg::FRAME_ADDR + snap_reg.code;

    always_comb
    begin
        case (idx_reg)
            swsp_pkg::IDX_HEAD: frame_byte = swsp_pkg::FRAME_HEAD;
            swsp_pkg::IDX_ADDR: frame_byte = swsp_pkg::FRAME_ADDR;
            swsp_pkg::IDX_CODE: frame_byte = snap_reg.code;
            swsp_pkg::IDX_SUM:  frame_byte = sum;
            swsp_pkg::IDX_TAIL: frame_byte = swsp_pkg::FRAME_TAIL;
            default:            frame_byte = 8'd0;
        endcase
    end

    assign out_valid         = valid_reg;
    assign kind              = on_status ? swsp_pkg::KIND_STATUS : swsp_pkg::KIND_FRAME;
    assign last              = on_status;
    assign line_drive        = snap_reg.line_drive;
    assign busy_res          = snap_reg.busy;
    assign outcome           = on_status ? snap_reg.outcome : swsp_pkg::OUTCOME_NONE;
    assign pulses_seen       = snap_reg.pulse_count;
    assign retries_remaining = snap_reg.retries;

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!valid_reg || (on_status && out_ready)))
        else $error("queue loaded while holding undelivered beats");

    a_tail_then_status: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_ready && idx_reg == swsp_pkg::IDX_TAIL && !load)
        |=> (valid_reg && on_status))
        else $error("status beat did not follow the frame tail");

    a_frame_while_driving: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !on_status) |-> (snap_reg.line_drive && snap_reg.busy))
        else $error("frame byte shown while the line is not driven");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (idx_reg <= swsp_pkg::IDX_STATUS))
        else $error("queue index out of range");

endmodule

@@ design/single_wire_sensor_pulse_handshake.sv @@
// ============================================================================
// single_wire_sensor_pulse_handshake: single-wire sensor link controller
// Sends check or calibrate frames, turns the line around and qualifies the
// sensor's reply pulses, reporting frame bytes and status per item.
// ============================================================================
//
//  Channel   Direction  Handshake             Payload
//  -------   ---------  --------------------  -----------------------------------
//  cfg       in         cfg_we                cfg_index, cfg_data
//  in        in         in_valid / in_ready   cmd, request_kind, pin_level
//  out       out        out_valid / out_ready kind, frame_byte, last, line_drive,
//                                             busy_res, outcome, pulses_seen,
//                                             retries_remaining
//
//  An item is applied to the link state in the cycle it is accepted, and its
//  results leave from the output queue one beat per cycle on the next cycles.
//  Items with a single status beat flow at one per cycle; a send tick fills
//  the queue with six beats (five frame bytes and status), which sets the rate.
//  A new item is taken in the cycle the previous item's status beat leaves.
//  Reset restores the register defaults and leaves the link idle with no beat
//  pending; a stalled output holds the queue and with it the input.
//
module single_wire_sensor_pulse_handshake (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [swsp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [swsp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                cmd,
    input  logic                                request_kind,
    input  logic                                pin_level,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                kind,
    output logic [7:0]                          frame_byte,
    output logic                                last,
    output logic                                line_drive,
    output logic                                busy_res,
    output logic [1:0]                          outcome,
    output logic [7:0]                          pulses_seen,
    output logic [7:0]                          retries_remaining
);

    logic                   accept;
    logic                   free;
    swsp_pkg::swsp_snap_t   snap;

    assign in_ready = free;
    assign accept   = in_valid && free;

    swsp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .step         (accept),
        .cmd          (cmd),
        .request_kind (request_kind),
        .pin_level    (pin_level),
        .snap         (snap)
    );

    swsp_txq u_txq (
        .clk               (clk),
        .rst_n             (rst_n),
        .load              (accept),
        .snap              (snap),
        .free              (free),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .kind              (kind),
        .frame_byte        (frame_byte),
        .last              (last),
        .line_drive        (line_drive),
        .busy_res          (busy_res),
        .outcome           (outcome),
        .pulses_seen       (pulses_seen),
        .retries_remaining (retries_remaining)
    );

endmodule

@@ sim/single_wire_sensor_pulse_handshake_checker.sv @@
// ============================================================================
// single_wire_sensor_pulse_handshake_checker: link predictor and beat checker
// Watches the register port and both handshake channels, keeps its own model
// of the sensor link, and compares every output beat with the oldest one
// predicted. It reports mismatches, the beats still owed and the link state.
// ============================================================================
module single_wire_sensor_pulse_handshake_checker
    import swsp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic                   cmd,
    input  logic                   request_kind,
    input  logic                   pin_level,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic                   kind,
    input  logic [7:0]             frame_byte,
    input  logic                   last,
    input  logic                   line_drive,
    input  logic                   busy_res,
    input  logic [1:0]             outcome,
    input  logic [7:0]             pulses_seen,
    input  logic [7:0]             retries_remaining,
    output int unsigned            mismatch_count,
    output int unsigned            beats_pending,
    output logic                   link_busy
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {LINK_IDLE, LINK_SEND, LINK_DRIVE, LINK_LISTEN} link_phase_t;
    typedef enum logic [1:0] {TRACK_CLEAR, TRACK_LOW, TRACK_HIGH} track_phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] frame_byte;
        logic       last;
        logic       line_drive;
        logic       busy;
        logic [1:0] outcome;
        logic [7:0] pulses;
        logic [7:0] retries;
    } link_beat_t;

    // Entry 0 holds the status check setting, entry 1 the calibration one.
    logic [7:0]   code_reg    [2];
    logic [7:0]   pulses_reg  [2];
    logic [7:0]   retries_reg [2];
    logic [15:0]  wait_reg    [2];

    link_phase_t  link_phase;
    track_phase_t track_phase;
    logic         calib;
    logic [7:0]   retries_left;
    logic [7:0]   pulse_count;
    logic [7:0]   pulse_timer;
    logic [4:0]   turn_timer;
    logic [15:0]  wait_timer;
    logic         prior_level;
    link_beat_t   expected_beats [$];

    function automatic string show_beat(input link_beat_t b);
        return $sformatf("kind=%0d byte=%02h last=%0d drive=%0d busy=%0d outcome=%0d pulses=%0d retries=%0d",
                         b.kind, b.frame_byte, b.last, b.line_drive, b.busy, b.outcome,
                         b.pulses, b.retries);
    endfunction

    task automatic push_beat(input logic beat_kind, input logic [7:0] byte_val,
                             input logic [1:0] result);
        link_beat_t b;
        b.kind       = beat_kind;
        b.frame_byte = byte_val;
        b.last       = (beat_kind == KIND_STATUS);
        b.line_drive = (link_phase == LINK_DRIVE);
        b.busy       = (link_phase != LINK_IDLE);
        b.outcome    = result;
        b.pulses     = pulse_count;
        b.retries    = retries_left;
        expected_beats.push_back(b);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_CHECK_CODE:    code_reg[0]    = value[7:0];
            REG_CALIB_CODE:    code_reg[1]    = value[7:0];
            REG_CHECK_PULSES:  pulses_reg[0]  = value[7:0];
            REG_CALIB_PULSES:  pulses_reg[1]  = value[7:0];
            REG_CHECK_RETRIES: retries_reg[0] = value[7:0];
            REG_CALIB_RETRIES: retries_reg[1] = value[7:0];
            REG_CHECK_WAIT:    wait_reg[0]    = value;
            REG_CALIB_WAIT:    wait_reg[1]    = value;
            default: ;
        endcase
    endtask

    // A pulse qualifies when the line stays low 3 to 7 ticks and then high
    // for at least 4 ticks.
    task automatic track_line(input logic pin);
        if (pulse_timer != COUNT_MAX)
            pulse_timer = pulse_timer + 8'd1;
        if (!pin && prior_level)
        begin
            if (track_phase == TRACK_CLEAR)
            begin
                pulse_timer = '0;
                track_phase = TRACK_LOW;
            end
            else if (track_phase == TRACK_HIGH && pulse_timer < PULSE_MIN)
                track_phase = TRACK_CLEAR;
        end
        else if (pin && !prior_level)
        begin
            if (track_phase == TRACK_LOW)
            begin
                if (pulse_timer >= PULSE_MIN && pulse_timer <= PULSE_MAX)
                begin
                    pulse_timer = '0;
                    track_phase = TRACK_HIGH;
                end
                else
                    track_phase = TRACK_CLEAR;
            end
        end
        else if (pin && prior_level)
        begin
            if (track_phase == TRACK_HIGH && pulse_timer >= PULSE_MIN)
            begin
                if (pulse_count != COUNT_MAX)
                    pulse_count = pulse_count + 8'd1;
                track_phase = TRACK_CLEAR;
            end
        end
    endtask

    // The window is taken in plain integers so that it never wraps.
    function automatic logic [1:0] judge_attempt();
        int target;
        int seen;
        target = int'(pulses_reg[calib]);
        seen   = int'(pulse_count);
        if (seen >= target - int'(TOLERANCE) && seen <= target + int'(TOLERANCE))
        begin
            link_phase = LINK_IDLE;
            return OUTCOME_PASS;
        end
        if (retries_left <= 8'd1)
        begin
            retries_left = '0;
            link_phase   = LINK_IDLE;
            return OUTCOME_FAIL;
        end
        retries_left = retries_left - 8'd1;
        link_phase   = LINK_SEND;
        return OUTCOME_NONE;
    endfunction

    task automatic predict_item(input logic c, input logic k, input logic pin);
        logic [1:0] result;
        logic [7:0] code;
        logic [7:0] sum;
        result = OUTCOME_NONE;
        if (c == CMD_START)
        begin
            // A start drops any request in progress and leaves the line history alone.
            calib        = k;
            retries_left = retries_reg[k];
            link_phase   = LINK_SEND;
            wait_timer   = '0;
            push_beat(KIND_STATUS, 8'h00, OUTCOME_NONE);
        end
        else
        begin
            case (link_phase)
                LINK_SEND:
                begin
                    code        = code_reg[calib];
                    sum         = FRAME_HEAD + FRAME_ADDR + code;
                    link_phase  = LINK_DRIVE;
                    track_phase = TRACK_CLEAR;
                    pulse_count = '0;
                    pulse_timer = '0;
                    turn_timer  = '0;
                    wait_timer  = wait_reg[calib];
                    push_beat(KIND_FRAME, FRAME_HEAD, OUTCOME_NONE);
                    push_beat(KIND_FRAME, FRAME_ADDR, OUTCOME_NONE);
                    push_beat(KIND_FRAME, code, OUTCOME_NONE);
                    push_beat(KIND_FRAME, sum, OUTCOME_NONE);
                    push_beat(KIND_FRAME, FRAME_TAIL, OUTCOME_NONE);
                end
                LINK_DRIVE:
                begin
                    if (turn_timer != TURN_MAX)
                        turn_timer = turn_timer + 5'd1;
                    if (wait_timer != 0)
                        wait_timer = wait_timer - 16'd1;
                    if (turn_timer > TURN_TICKS)
                        link_phase = LINK_LISTEN;
                end
                LINK_LISTEN:
                begin
                    if (wait_timer != 0)
                        wait_timer = wait_timer - 16'd1;
                    track_line(pin);
                    if (wait_timer == 0)
                        result = judge_attempt();
                end
                default: ;
            endcase
            prior_level = pin;
            push_beat(KIND_STATUS, 8'h00, result);
        end
    endtask

    always @(posedge clk)
    begin : monitor
        link_beat_t got;
        link_beat_t want;
        if (!rst_n)
        begin
            code_reg[0]    = 8'd1;
            code_reg[1]    = 8'd2;
            pulses_reg[0]  = 8'd10;
            pulses_reg[1]  = 8'd20;
            retries_reg[0] = 8'd3;
            retries_reg[1] = 8'd3;
            wait_reg[0]    = 16'd250;
            wait_reg[1]    = 16'd500;
            link_phase     = LINK_IDLE;
            track_phase    = TRACK_CLEAR;
            calib          = 1'b0;
            retries_left   = '0;
            pulse_count    = '0;
            pulse_timer    = '0;
            turn_timer     = '0;
            wait_timer     = '0;
            prior_level    = 1'b0;
            mismatch_count = 0;
            expected_beats.delete();
        end
        else
        begin
            if (cfg_we)
                write_register(cfg_index, cfg_data);
            if (in_valid && in_ready)
                predict_item(cmd, request_kind, pin_level);
            if (out_valid && out_ready)
            begin
                got = {kind, frame_byte, last, line_drive, busy_res, outcome,
                       pulses_seen, retries_remaining};
                if (expected_beats.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: beat with nothing expected: %s", $realtime, show_beat(got));
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: beat mismatch\n  expected %s\n  actual   %s",
                                     $realtime, show_beat(want), show_beat(got));
                    end
                end
            end
        end
        beats_pending <= expected_beats.size();
        link_busy     <= (link_phase != LINK_IDLE);
    end

endmodule

@@ sim/single_wire_sensor_pulse_handshake_tb.sv @@
// ============================================================================
// single_wire_sensor_pulse_handshake_tb: testbench of the sensor link
// Drives check and calibration requests with shaped reply pulses on the line
// through several register settings, with random gaps on both channels and a
// long output stall, and takes the verdict from the beat checker.
// ============================================================================
module single_wire_sensor_pulse_handshake_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swsp_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 500000;
    localparam int unsigned HOLD_OFF_CYCLES = 250;
    localparam int unsigned PHASE_ITEMS     = 45;
    localparam int          SETTING_COUNT   = 5;
    localparam int          PRESSURE_PHASE  = 1;
    localparam int          STEADY_PHASE    = 3;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic                   cmd;
    logic                   request_kind;
    logic                   pin_level;
    logic                   out_valid;
    logic                   out_ready;
    logic                   kind;
    logic [7:0]             frame_byte;
    logic                   last;
    logic                   line_drive;
    logic                   busy_res;
    logic [1:0]             outcome;
    logic [7:0]             pulses_seen;
    logic [7:0]             retries_remaining;
    int unsigned            mismatch_count;
    int unsigned            beats_pending;
    logic                   link_busy;

    logic [CFG_DATA_W-1:0]  cfg_sets [SETTING_COUNT][8];
    logic                   steady = 1'b0;
    logic                   hold_off = 1'b0;
    logic                   line_level = 1'b1;
    int unsigned            run_left = 0;
    int unsigned            cycle_count = 0;

    single_wire_sensor_pulse_handshake dut (.*);

    single_wire_sensor_pulse_handshake_checker checker_inst (.*);

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int unsigned draw_gap();
        return steady ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic define_setting(input int s, input logic [7:0] check_code,
                                  input logic [7:0] calib_code, input logic [7:0] check_pulses,
                                  input logic [7:0] calib_pulses, input logic [7:0] check_retries,
                                  input logic [7:0] calib_retries, input logic [15:0] check_wait,
                                  input logic [15:0] calib_wait);
        cfg_sets[s][REG_CHECK_CODE]    = check_code;
        cfg_sets[s][REG_CALIB_CODE]    = calib_code;
        cfg_sets[s][REG_CHECK_PULSES]  = check_pulses;
        cfg_sets[s][REG_CALIB_PULSES]  = calib_pulses;
        cfg_sets[s][REG_CHECK_RETRIES] = check_retries;
        cfg_sets[s][REG_CALIB_RETRIES] = calib_retries;
        cfg_sets[s][REG_CHECK_WAIT]    = check_wait;
        cfg_sets[s][REG_CALIB_WAIT]    = calib_wait;
    endtask

    // Registers change only with no beat owed and the link idle.
    task automatic load_config(input int s);
        // The last item offered is already taken, so stop offering it.
        in_valid <= 1'b0;
        while (beats_pending != 0 || link_busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
        for (int r = 0; r < 8; r++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_INDEX_W'(r);
            cfg_data  <= cfg_sets[s][r];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_item(input logic c, input logic k, input logic pin);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd          <= c;
        request_kind <= k;
        pin_level    <= pin;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Line waveform: mostly well-shaped pulses, with short and overlong runs
    // mixed in so that the tracker also sees broken pulses.
    task automatic tick();
        if (run_left == 0)
        begin
            line_level = !line_level;
            if ($urandom_range(0, 99) < 85)
                run_left = line_level ? $urandom_range(3, 6) : $urandom_range(3, 7);
            else if ($urandom_range(0, 1) == 1)
                run_left = $urandom_range(1, 2);
            else
                run_left = $urandom_range(8, 12);
        end
        run_left--;
        send_item(CMD_TICK, 1'($urandom_range(0, 1)), line_level);
    endtask

    initial
    begin : receiver
        int unsigned stall;
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off = 1'b0;
            end
            stall = draw_gap();
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin : stimulus
        logic        k;
        int unsigned w;
        int unsigned n;
        int unsigned phase_items;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_CHECK_CODE;
        cfg_data     = '0;
        in_valid     = 1'b0;
        cmd          = CMD_TICK;
        request_kind = 1'b0;
        pin_level    = 1'b0;

        define_setting(0, 8'hFF, 8'h00, 8'd4, 8'd251, 8'd1, 8'd255, 16'd1, 16'hFFFF);
        define_setting(1, 8'h5A, 8'hA5, 8'd4, 8'd9, 8'd2, 8'd3, 16'd20, 16'd14);
        define_setting(2, 8'h80, 8'h7F, 8'd0, 8'd255, 8'd0, 8'd0, 16'd0, 16'd24);
        define_setting(3, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'd5, 8'd6, 8'd3, 8'd1, 16'd24, 16'd18);
        define_setting(4, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(4, 10)), 8'($urandom_range(4, 10)),
                       8'($urandom_range(1, 2)), 8'($urandom_range(1, 2)),
                       16'($urandom_range(1, 24)), 16'($urandom_range(1, 24)));

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        load_config(0);

        // Ticks with no request, then a calibration with the longest wait that
        // is cut short by a status check, which passes on its first listening tick.
        send_item(CMD_TICK, 1'b0, 1'b1);
        send_item(CMD_TICK, 1'b1, 1'b0);
        send_item(CMD_START, 1'b1, 1'b1);
        tick();
        tick();
        send_item(CMD_START, 1'b0, 1'b0);
        repeat (18) tick();

        for (int s = 1; s < SETTING_COUNT; s++)
        begin
            while (link_busy)
                tick();
            load_config(s);
            steady = (s == STEADY_PHASE);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                k = 1'($urandom_range(0, 1));
                send_item(CMD_START, k, 1'($urandom_range(0, 1)));
                if (s == PRESSURE_PHASE && phase_items == 0)
                    hold_off = 1'b1;
                w = k ? cfg_sets[s][REG_CALIB_WAIT] : cfg_sets[s][REG_CHECK_WAIT];
                // Short runs restart the request in the middle of an attempt.
                n = $urandom_range(4, 2 * (w + 17));
                repeat (n) tick();
                phase_items += n + 1;
            end
        end
        while (link_busy)
            tick();
        in_valid <= 1'b0;

        while (beats_pending != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
design/swsp_pkg.sv
design/swsp_ctrl.sv
design/swsp_txq.sv
design/single_wire_sensor_pulse_handshake.sv
sim/single_wire_sensor_pulse_handshake_checker.sv
sim/single_wire_sensor_pulse_handshake_tb.sv
